>>> design/bfs_pkg.sv
`timescale 1ns / 1ps
// Shared constants and helpers for the bilinear frame scaler.
// No dependencies.
package bfs_pkg;

	localparam int MAX_SRC_WIDTH_D  = 512;
	localparam int MAX_SRC_HEIGHT_D = 256;
	localparam int MAX_BUFFER_DIM_D = 1024;

	// register indexes on the configuration port
	localparam logic [2:0] CFG_SRC_WIDTH     = 3'd0;
	localparam logic [2:0] CFG_SRC_HEIGHT    = 3'd1;
	localparam logic [2:0] CFG_DEST_WIDTH    = 3'd2;
	localparam logic [2:0] CFG_DEST_HEIGHT   = 3'd3;
	localparam logic [2:0] CFG_BUFFER_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_BUFFER_HEIGHT = 3'd5;
	localparam logic [2:0] CFG_PIXEL_FORMAT  = 3'd6;

	localparam logic [9:0]  SRC_WIDTH_RST     = 10'd512;
	localparam logic [8:0]  SRC_HEIGHT_RST    = 9'd256;
	localparam logic [10:0] DEST_WIDTH_RST    = 11'd640;
	localparam logic [10:0] DEST_HEIGHT_RST   = 11'd480;
	localparam logic [10:0] BUFFER_WIDTH_RST  = 11'd640;
	localparam logic [10:0] BUFFER_HEIGHT_RST = 11'd480;

	localparam logic PIX_RGB565   = 1'b0;
	localparam logic PIX_ARGB8888 = 1'b1;

	// floor(c*255/31) through a reciprocal multiply (2^20/31 rounded up)
	function automatic logic [7:0] expand5(input logic [4:0] c);
		logic [31:0] t;
		t = 32'(c) * 32'd255 * 32'd33826;
		return t[27:20];
	endfunction

	// floor(c*255/63), reciprocal 2^20/63 rounded up
	function automatic logic [7:0] expand6(input logic [5:0] c);
		logic [31:0] t;
		t = 32'(c) * 32'd255 * 32'd16645;
		return t[27:20];
	endfunction

endpackage

>>> design/bilinear_frame_scaler.sv
`timescale 1ns / 1ps
// Bilinear frame scaler: banked source store, step divider and sample pipeline.
// Depends on bfs_pkg.
//
// Usage:
//  - Request channel: a request is taken at a clock edge with start high and
//    busy low. operation 0 writes pixel_in into the source store at
//    (coord_x, coord_y); operation 1 samples destination pixel (coord_x, coord_y).
//  - Results: done is high for one cycle with out_x, out_y and pixel_out.
//    A sample outside the destination area and every write give no result.
//  - Pipeline: six register stages (input, position multiply, neighbor select
//    and store read, channel expand, weight multiply, blend and pack) lie
//    between an accepted sample and its done.
//  - Throughput: one request per clock unless busy; the store is split into four
//    banks by column and row parity so all four neighbors are read together.
//  - Config: cfg_we writes register cfg_index with cfg_data. Each write starts
//    the step divider for the 10.16 (x) and 9.16 (y) steps at default sizes:
//    a load state, then one quotient bit per cycle per axis; busy is high for
//    all of it.
//  - Reset: registers take their reset values, then the divider runs once,
//    so busy stays high until it ends. The store is not cleared.
//  - The receiver cannot hold results off; none are ever stalled.
module bilinear_frame_scaler #(
	parameter int MAX_SRC_WIDTH  = bfs_pkg::MAX_SRC_WIDTH_D,
	parameter int MAX_SRC_HEIGHT = bfs_pkg::MAX_SRC_HEIGHT_D,
	parameter int MAX_BUFFER_DIM = bfs_pkg::MAX_BUFFER_DIM_D
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [9:0]  coord_x,
	input  logic [9:0]  coord_y,
	input  logic [31:0] pixel_in,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [10:0] cfg_data,
	output logic        done,
	output logic [9:0]  out_x,
	output logic [9:0]  out_y,
	output logic [31:0] pixel_out
);

	localparam int SWW   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int SHW   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int XW    = $clog2(MAX_SRC_WIDTH);
	localparam int YW    = $clog2(MAX_SRC_HEIGHT);
	localparam int SXW   = SWW + 16;
	localparam int SYW   = SHW + 16;
	localparam int NDIV  = (SXW > SYW) ? SXW : SYW;
	localparam int CNTW  = $clog2(NDIV + 1);
	localparam int HW    = (MAX_SRC_WIDTH + 1) / 2;
	localparam int HH    = (MAX_SRC_HEIGHT + 1) / 2;
	localparam int BDEPTH = HW * HH;
	localparam int BAW   = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOAD = 3'b010,
		ST_DIV  = 3'b100
	} div_state_t;

	// configuration
	logic [9:0]  src_width_q;
	logic [8:0]  src_height_q;
	logic [10:0] dest_width_q, dest_height_q, buffer_width_q, buffer_height_q;
	logic        pixel_format_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q     <= bfs_pkg::SRC_WIDTH_RST;
			src_height_q    <= bfs_pkg::SRC_HEIGHT_RST;
			dest_width_q    <= bfs_pkg::DEST_WIDTH_RST;
			dest_height_q   <= bfs_pkg::DEST_HEIGHT_RST;
			buffer_width_q  <= bfs_pkg::BUFFER_WIDTH_RST;
			buffer_height_q <= bfs_pkg::BUFFER_HEIGHT_RST;
			pixel_format_q  <= bfs_pkg::PIX_RGB565;
		end else if (cfg_we) begin
			case (cfg_index)
				bfs_pkg::CFG_SRC_WIDTH:     src_width_q     <= cfg_data[9:0];
				bfs_pkg::CFG_SRC_HEIGHT:    src_height_q    <= cfg_data[8:0];
				bfs_pkg::CFG_DEST_WIDTH:    dest_width_q    <= cfg_data;
				bfs_pkg::CFG_DEST_HEIGHT:   dest_height_q   <= cfg_data;
				bfs_pkg::CFG_BUFFER_WIDTH:  buffer_width_q  <= cfg_data;
				bfs_pkg::CFG_BUFFER_HEIGHT: buffer_height_q <= cfg_data;
				bfs_pkg::CFG_PIXEL_FORMAT:  pixel_format_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// effective sizes
	logic [SWW-1:0] sw;
	logic [SHW-1:0] sh;
	logic [10:0]    bw, bh, dw, dh, den_x, den_y;

	always_comb begin
		if (src_width_q == 10'd0) sw = SWW'(1);
		else if (int'(src_width_q) > MAX_SRC_WIDTH) sw = SWW'(MAX_SRC_WIDTH);
		else sw = SWW'(src_width_q);
		if (src_height_q == 9'd0) sh = SHW'(1);
		else if (int'(src_height_q) > MAX_SRC_HEIGHT) sh = SHW'(MAX_SRC_HEIGHT);
		else sh = SHW'(src_height_q);
		bw = (int'(buffer_width_q) > MAX_BUFFER_DIM) ? 11'(MAX_BUFFER_DIM) : buffer_width_q;
		bh = (int'(buffer_height_q) > MAX_BUFFER_DIM) ? 11'(MAX_BUFFER_DIM) : buffer_height_q;
		dw = (dest_width_q < bw) ? dest_width_q : bw;
		dh = (dest_height_q < bh) ? dest_height_q : bh;
		den_x = (dw > 11'd1) ? dw - 11'd1 : 11'd1;
		den_y = (dh > 11'd1) ? dh - 11'd1 : 11'd1;
	end

	// step divider: restoring, one quotient bit per cycle for both axes
	div_state_t     state_q;
	logic [CNTW-1:0] cnt_q;
	logic [NDIV-1:0] numx_q, numy_q;
	logic [10:0]     remx_q, remy_q;
	logic [SXW-1:0]  step_x_q;
	logic [SYW-1:0]  step_y_q;
	logic [11:0]     tx, ty;

	assign tx = {remx_q, numx_q[NDIV-1]};
	assign ty = {remy_q, numy_q[NDIV-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
		end else if (cfg_we) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					state_q <= ST_DIV;
					cnt_q   <= '0;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + CNTW'(1);
					if (cnt_q == CNTW'(NDIV - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: ;
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_LOAD: begin
				numx_q <= NDIV'({sw - SWW'(1), 16'd0});
				numy_q <= NDIV'({sh - SHW'(1), 16'd0});
				remx_q <= '0;
				remy_q <= '0;
			end
			ST_DIV: begin
				if (tx >= {1'b0, den_x}) begin
					remx_q <= 11'(tx - {1'b0, den_x});
					numx_q <= {numx_q[NDIV-2:0], 1'b1};
				end else begin
					remx_q <= tx[10:0];
					numx_q <= {numx_q[NDIV-2:0], 1'b0};
				end
				if (ty >= {1'b0, den_y}) begin
					remy_q <= 11'(ty - {1'b0, den_y});
					numy_q <= {numy_q[NDIV-2:0], 1'b1};
				end else begin
					remy_q <= ty[10:0];
					numy_q <= {numy_q[NDIV-2:0], 1'b0};
				end
				if (cnt_q == CNTW'(NDIV - 1)) begin
					step_x_q <= SXW'({numx_q[NDIV-2:0], (tx >= {1'b0, den_x})});
					step_y_q <= SYW'({numy_q[NDIV-2:0], (ty >= {1'b0, den_y})});
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

	// stage 1: request register
	logic        v_s1, op_s1;
	logic [9:0]  cx_s1, cy_s1;
	logic [31:0] pin_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else v_s1 <= start && !busy;
	end

	always_ff @(posedge clk) begin
		op_s1  <= operation;
		cx_s1  <= coord_x;
		cy_s1  <= coord_y;
		pin_s1 <= pixel_in;
	end

	// stage 2: range checks and source positions
	logic                smp_s2, wr_s2;
	logic [9:0]          cx_s2, cy_s2;
	logic [31:0]         pin_s2;
	logic [SXW+9:0]      fx_s2;
	logic [SYW+9:0]      fy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s2 <= 1'b0;
			wr_s2  <= 1'b0;
		end else begin
			smp_s2 <= v_s1 && op_s1 && ({1'b0, cx_s1} < dw) && ({1'b0, cy_s1} < dh);
			wr_s2  <= v_s1 && !op_s1 && (int'(cx_s1) < MAX_SRC_WIDTH)
			          && (int'(cy_s1) < MAX_SRC_HEIGHT);
		end
	end

	always_ff @(posedge clk) begin
		cx_s2  <= cx_s1;
		cy_s2  <= cy_s1;
		pin_s2 <= pin_s1;
		fx_s2  <= (SXW+10)'(cx_s1) * (SXW+10)'(step_x_q);
		fy_s2  <= (SYW+10)'(cy_s1) * (SYW+10)'(step_y_q);
	end

	// stage 2 logic: neighbors, weights, bank addresses
	logic [SWW-1:0] sw1;
	logic [SHW-1:0] sh1;
	logic [XW-1:0]  x0, x1;
	logic [YW-1:0]  y0, y1;
	logic [16:0]    wx1, wx0, wy1, wy0;
	logic [33:0]    p_00, p_10, p_01, p_11;

	always_comb begin
		sw1 = sw - SWW'(1);
		sh1 = sh - SHW'(1);
		x0 = (fx_s2[SXW+9:16] > (SXW-6)'(sw1)) ? XW'(sw1) : XW'(fx_s2[SXW+9:16]);
		y0 = (fy_s2[SYW+9:16] > (SYW-6)'(sh1)) ? YW'(sh1) : YW'(fy_s2[SYW+9:16]);
		x1 = (SWW'(x0) < sw1) ? XW'(x0 + XW'(1)) : x0;
		y1 = (SHW'(y0) < sh1) ? YW'(y0 + YW'(1)) : y0;
		wx1 = {1'b0, fx_s2[15:0]};
		wy1 = {1'b0, fy_s2[15:0]};
		wx0 = 17'h10000 - wx1;
		wy0 = 17'h10000 - wy1;
		p_00 = 34'(wx0) * 34'(wy0);
		p_10 = 34'(wx1) * 34'(wy0);
		p_01 = 34'(wx0) * 34'(wy1);
		p_11 = 34'(wx1) * 34'(wy1);
	end

	// four banks, indexed {row parity, column parity}
	logic [BAW-1:0] rd_addr [4];
	logic [BAW-1:0] wr_addr;
	logic [31:0]    rd_s3 [4];

	assign wr_addr = BAW'((int'(cy_s2) / 2) * HW + int'(cx_s2) / 2);

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [31:0]    mem [BDEPTH];
		logic [XW-1:0]  col;
		logic [YW-1:0]  row;

		always_comb begin
			col = (x0[0] == b[0]) ? x0 : x1;
			row = (y0[0] == b[1]) ? y0 : y1;
			rd_addr[b] = BAW'((int'(row) / 2) * HW + int'(col) / 2);
		end

		always_ff @(posedge clk) begin
			if (wr_s2 && cx_s2[0] == b[0] && cy_s2[0] == b[1]) mem[wr_addr] <= pin_s2;
			rd_s3[b] <= mem[rd_addr[b]];
		end
	end

	// stage 3
	logic        smp_s3;
	logic        x0p_s3, x1p_s3, y0p_s3, y1p_s3;
	logic [17:0] w_s3 [4];
	logic [9:0]  ox_s3, oy_s3;
	logic [10:0] offx, offy;

	assign offx = (bw - dw) >> 1;
	assign offy = (bh - dh) >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) smp_s3 <= 1'b0;
		else smp_s3 <= smp_s2;
	end

	always_ff @(posedge clk) begin
		x0p_s3 <= x0[0];
		x1p_s3 <= x1[0];
		y0p_s3 <= y0[0];
		y1p_s3 <= y1[0];
		w_s3[0] <= p_00[33:16];
		w_s3[1] <= p_10[33:16];
		w_s3[2] <= p_01[33:16];
		w_s3[3] <= p_11[33:16];
		ox_s3 <= 10'(offx + {1'b0, cx_s2});
		oy_s3 <= 10'(offy + {1'b0, cy_s2});
	end

	// stage 3 logic: pick neighbors, expand channels (order 00,10,01,11)
	logic [31:0] nb [4];
	logic [7:0]  ch [3][4];

	always_comb begin
		nb[0] = rd_s3[{y0p_s3, x0p_s3}];
		nb[1] = rd_s3[{y0p_s3, x1p_s3}];
		nb[2] = rd_s3[{y1p_s3, x0p_s3}];
		nb[3] = rd_s3[{y1p_s3, x1p_s3}];
		for (int n = 0; n < 4; n++) begin
			if (pixel_format_q == bfs_pkg::PIX_ARGB8888) begin
				ch[0][n] = nb[n][23:16];
				ch[1][n] = nb[n][15:8];
				ch[2][n] = nb[n][7:0];
			end else begin
				ch[0][n] = bfs_pkg::expand5(nb[n][15:11]);
				ch[1][n] = bfs_pkg::expand6(nb[n][10:5]);
				ch[2][n] = bfs_pkg::expand5(nb[n][4:0]);
			end
		end
	end

	// stage 4
	logic        smp_s4;
	logic [7:0]  ch_s4 [3][4];
	logic [17:0] w_s4 [4];
	logic [9:0]  ox_s4, oy_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) smp_s4 <= 1'b0;
		else smp_s4 <= smp_s3;
	end

	always_ff @(posedge clk) begin
		ch_s4 <= ch;
		w_s4  <= w_s3;
		ox_s4 <= ox_s3;
		oy_s4 <= oy_s3;
	end

	// stage 5: weighted terms
	logic        smp_s5;
	logic [25:0] prod_s5 [3][4];
	logic [9:0]  ox_s5, oy_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) smp_s5 <= 1'b0;
		else smp_s5 <= smp_s4;
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++)
			for (int n = 0; n < 4; n++)
				prod_s5[c][n] <= 26'(ch_s4[c][n]) * 26'(w_s4[n]);
		ox_s5 <= ox_s4;
		oy_s5 <= oy_s4;
	end

	// stage 5 logic: blend and repack
	logic [27:0] sum [3];
	logic [7:0]  v [3];
	logic [31:0] pix;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum[c] = 28'(prod_s5[c][0]) + 28'(prod_s5[c][1])
			       + 28'(prod_s5[c][2]) + 28'(prod_s5[c][3]);
			v[c] = sum[c][23:16];
		end
		if (pixel_format_q == bfs_pkg::PIX_ARGB8888)
			pix = {8'hff, v[0], v[1], v[2]};
		else
			pix = {16'd0, v[0][7:3], v[1][7:2], v[2][7:3]};
	end

	// stage 6: result register
	logic        done_s6;
	logic [9:0]  ox_s6, oy_s6;
	logic [31:0] pix_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_s6 <= 1'b0;
		else done_s6 <= smp_s5;
	end

	always_ff @(posedge clk) begin
		ox_s6  <= ox_s5;
		oy_s6  <= oy_s5;
		pix_s6 <= pix;
	end

	assign done      = done_s6;
	assign out_x     = ox_s6;
	assign out_y     = oy_s6;
	assign pixel_out = pix_s6;

`ifndef NO_ASSERTIONS
	// a store write never yields a result
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !operation) |-> ##6 !done)
		else $error("write request produced a result");

	// an in-area sample always yields a result
	a_sample_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation && ({1'b0, coord_x} < dw) && ({1'b0, coord_y} < dh))
		|-> ##6 done)
		else $error("in-area sample lost");

	// a config write restarts the step divider
	a_cfg_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> busy)
		else $error("config write did not raise busy");
`endif

endmodule

>>> tb/sv/bilinear_frame_scaler_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for bilinear_frame_scaler: each phase sets the registers,
// fills the source area, then issues directed and random requests against a predictor.
// Depends on bfs_pkg and the bilinear_frame_scaler RTL.
module bilinear_frame_scaler_tb;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;
	localparam int   STORE_W   = 512;
	localparam int   STORE_H   = 256;
	localparam int   LAT_SLACK = 12;      // pipeline is six stages deep
	localparam int   CYCLE_CAP = 400000;

	typedef struct packed {
		logic        op;
		logic [9:0]  x;
		logic [9:0]  y;
		logic [31:0] pix;
	} req_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [31:0] pix;
	} sample_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        operation;
	logic [9:0]  coord_x;
	logic [9:0]  coord_y;
	logic [31:0] pixel_in;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [10:0] cfg_data;
	logic        done;
	logic [9:0]  out_x;
	logic [9:0]  out_y;
	logic [31:0] pixel_out;

	bilinear_frame_scaler dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.operation(operation), .coord_x(coord_x), .coord_y(coord_y),
		.pixel_in(pixel_in), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .out_x(out_x), .out_y(out_y),
		.pixel_out(pixel_out)
	);

	// predictor state: shadow registers and a copy of the source store
	logic [9:0]  sh_src_w;
	logic [8:0]  sh_src_h;
	logic [10:0] sh_dst_w, sh_dst_h, sh_buf_w, sh_buf_h;
	logic        sh_argb;
	logic [31:0] frame_copy [STORE_W*STORE_H];

	req_t    pending_reqs[$];
	sample_t scaled_pixels[$];
	int      idle_pct;
	int      mismatches;
	int      cycles;
	bit      taken;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	// effective sizes after saturation and clamping
	function automatic int eff_src_w();
		return (sh_src_w == 0) ? 1 : (sh_src_w > STORE_W ? STORE_W : int'(sh_src_w));
	endfunction
	function automatic int eff_src_h();
		return (sh_src_h == 0) ? 1 : (sh_src_h > STORE_H ? STORE_H : int'(sh_src_h));
	endfunction
	function automatic int eff_buf_w();
		return sh_buf_w > bfs_pkg::MAX_BUFFER_DIM_D ? bfs_pkg::MAX_BUFFER_DIM_D
			: int'(sh_buf_w);
	endfunction
	function automatic int eff_buf_h();
		return sh_buf_h > bfs_pkg::MAX_BUFFER_DIM_D ? bfs_pkg::MAX_BUFFER_DIM_D
			: int'(sh_buf_h);
	endfunction
	function automatic int eff_dst_w();
		return sh_dst_w > eff_buf_w() ? eff_buf_w() : int'(sh_dst_w);
	endfunction
	function automatic int eff_dst_h();
		return sh_dst_h > eff_buf_h() ? eff_buf_h() : int'(sh_dst_h);
	endfunction

	function automatic longint unsigned step16(int s, int d);
		if (s <= 1)
			return 0;
		return (longint'(s - 1) << 16) / (d > 1 ? d - 1 : 1);
	endfunction

	// one 8-bit color channel; c = 0 red, 1 green, 2 blue
	function automatic longint unsigned channel(logic [31:0] p, int c);
		if (sh_argb)
			return (p >> (16 - 8 * c)) & 32'hff;
		case (c)
			0: return (longint'(p[15:11]) * 255) / 31;
			1: return (longint'(p[10:5]) * 255) / 63;
			default: return (longint'(p[4:0]) * 255) / 31;
		endcase
	endfunction

	// apply one accepted request to the predictor; samples inside the dest
	// area push the blended pixel at its centered buffer position
	task automatic scale_request(req_t r);
		int sw, sh, dw, dh, x0, y0, x1, y1;
		longint unsigned fx, fy, wx0, wx1, wy0, wy1, w00, w10, w01, w11, acc;
		logic [31:0] mask, p00, p10, p01, p11;
		logic [7:0] v [3];
		sample_t s;
		if (r.op == OP_WRITE) begin
			if (r.x < STORE_W && r.y < STORE_H)
				frame_copy[r.y * STORE_W + r.x] = r.pix;
			return;
		end
		sw = eff_src_w();
		sh = eff_src_h();
		dw = eff_dst_w();
		dh = eff_dst_h();
		if (r.x >= dw || r.y >= dh)
			return;
		fx = longint'(r.x) * step16(sw, dw);
		fy = longint'(r.y) * step16(sh, dh);
		x0 = (fx >> 16) > sw - 1 ? sw - 1 : int'(fx >> 16);
		y0 = (fy >> 16) > sh - 1 ? sh - 1 : int'(fy >> 16);
		x1 = x0 + 1 > sw - 1 ? sw - 1 : x0 + 1;
		y1 = y0 + 1 > sh - 1 ? sh - 1 : y0 + 1;
		wx1 = fx & 16'hffff;
		wx0 = 64'h10000 - wx1;
		wy1 = fy & 16'hffff;
		wy0 = 64'h10000 - wy1;
		w00 = (wx0 * wy0) >> 16;
		w10 = (wx1 * wy0) >> 16;
		w01 = (wx0 * wy1) >> 16;
		w11 = (wx1 * wy1) >> 16;
		mask = sh_argb ? 32'hffffffff : 32'h0000ffff;
		p00 = frame_copy[y0 * STORE_W + x0] & mask;
		p10 = frame_copy[y0 * STORE_W + x1] & mask;
		p01 = frame_copy[y1 * STORE_W + x0] & mask;
		p11 = frame_copy[y1 * STORE_W + x1] & mask;
		for (int c = 0; c < 3; c++) begin
			acc = channel(p00, c) * w00 + channel(p10, c) * w10
			    + channel(p01, c) * w01 + channel(p11, c) * w11;
			v[c] = acc[23:16];
		end
		s.x = 10'((eff_buf_w() - dw) / 2 + r.x);
		s.y = 10'((eff_buf_h() - dh) / 2 + r.y);
		if (sh_argb)
			s.pix = {8'hff, v[0], v[1], v[2]};
		else
			s.pix = {16'h0, v[0][7:3], v[1][7:2], v[2][7:3]};
		scaled_pixels.push_back(s);
	endtask

	// accept side and result checker, both on the rising edge
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_CAP) begin
			$display("Some tests failed");
			$finish;
		end
		if (arst_n && start && !busy) begin
			taken = 1'b1;
			scale_request('{operation, coord_x, coord_y, pixel_in});
		end
		if (arst_n && done) begin
			if (scaled_pixels.size() == 0) begin
				$error("result with none expected: out_x %0d out_y %0d pixel_out %h",
					out_x, out_y, pixel_out);
				mismatches++;
			end else begin
				sample_t e;
				e = scaled_pixels.pop_front();
				if (out_x !== e.x) begin
					$error("out_x expected %0d actual %0d", e.x, out_x);
					mismatches++;
				end
				if (out_y !== e.y) begin
					$error("out_y expected %0d actual %0d", e.y, out_y);
					mismatches++;
				end
				if (pixel_out !== e.pix) begin
					$error("pixel_out expected %h actual %h", e.pix, pixel_out);
					mismatches++;
				end
			end
		end
	end

	// request driver: holds a request until accepted, then pops the next one
	always @(negedge clk) begin
		if (arst_n && (!start || taken)) begin
			taken = 1'b0;
			if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
				req_t r;
				r = pending_reqs.pop_front();
				start     <= 1'b1;
				operation <= r.op;
				coord_x   <= r.x;
				coord_y   <= r.y;
				pixel_in  <= r.pix;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// wait until every request is in and every result is out, plus slack
	task automatic drain();
		while (pending_reqs.size() > 0 || start || scaled_pixels.size() > 0)
			@(posedge clk);
		repeat (LAT_SLACK) @(posedge clk);
	endtask

	task automatic write_regs(int sw, int sh, int dw, int dh, int bw, int bh, int fmt);
		int vals [7];
		logic [2:0] idx [7];
		vals = '{sw, sh, dw, dh, bw, bh, fmt};
		idx = '{bfs_pkg::CFG_SRC_WIDTH, bfs_pkg::CFG_SRC_HEIGHT,
			bfs_pkg::CFG_DEST_WIDTH, bfs_pkg::CFG_DEST_HEIGHT,
			bfs_pkg::CFG_BUFFER_WIDTH, bfs_pkg::CFG_BUFFER_HEIGHT,
			bfs_pkg::CFG_PIXEL_FORMAT};
		for (int i = 0; i < 7; i++) begin
			@(negedge clk);
			cfg_we    <= 1'b1;
			cfg_index <= idx[i];
			cfg_data  <= 11'(vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
		sh_src_w = 10'(sw);
		sh_src_h = 9'(sh);
		sh_dst_w = 11'(dw);
		sh_dst_h = 11'(dh);
		sh_buf_w = 11'(bw);
		sh_buf_h = 11'(bh);
		sh_argb  = fmt[0];
	endtask

	task automatic add_req(logic op, int x, int y, logic [31:0] pix);
		pending_reqs.push_back('{op, 10'(x), 10'(y), pix});
	endtask

	// one phase: registers, source fill (none when the dest area is empty),
	// a settle pause, then traffic
	task automatic run_phase(int sw, int sh, int dw, int dh, int bw, int bh, int fmt,
			int n_rand, bit directed);
		int w, h, ew, eh, pick;
		drain();
		write_regs(sw, sh, dw, dh, bw, bh, fmt);
		w = eff_src_w();
		h = eff_src_h();
		ew = eff_dst_w();
		eh = eff_dst_h();
		if (ew > 0 && eh > 0)
			for (int y = 0; y < h; y++)
				for (int x = 0; x < w; x++)
					add_req(OP_WRITE, x, y, $urandom());
		// sender holds off until the store fill has fully settled
		drain();
		if (directed) begin
			add_req(OP_SAMPLE, 0, 0, 32'h0);
			add_req(OP_SAMPLE, ew - 1, eh - 1, 32'hffffffff);
			add_req(OP_SAMPLE, ew - 1, 0, 32'h0);
			add_req(OP_SAMPLE, 0, eh - 1, 32'h0);
			add_req(OP_SAMPLE, ew, 0, 32'h0);          // just right of dest area
			add_req(OP_SAMPLE, 0, eh, 32'h0);          // just below dest area
			add_req(OP_SAMPLE, 1023, 1023, 32'h0);
			add_req(OP_WRITE, 1023, 1023, 32'hdeadbeef); // outside store, dropped
			add_req(OP_WRITE, 600, 3, 32'h12345678);     // column past store width
			add_req(OP_WRITE, STORE_W - 1, STORE_H - 1, 32'hffffffff);
			add_req(OP_WRITE, 0, 0, 32'hffffffff);
			add_req(OP_SAMPLE, 0, 0, 32'h0);
			add_req(OP_WRITE, 0, 0, 32'h0);
			add_req(OP_SAMPLE, 0, 0, 32'h0);
			add_req(OP_WRITE, 1, 1, 32'h0000f800);
			add_req(OP_SAMPLE, ew / 2, eh / 2, 32'h0);
		end
		for (int i = 0; i < n_rand; i++) begin
			pick = $urandom_range(99);
			if (pick < 70 && ew > 0 && eh > 0)
				add_req(OP_SAMPLE, $urandom_range(ew - 1), $urandom_range(eh - 1),
					$urandom());
			else if (pick < 85)
				add_req(OP_SAMPLE, $urandom_range(1023), $urandom_range(1023), $urandom());
			else if (pick < 93)
				add_req(OP_WRITE, $urandom_range(w - 1), $urandom_range(h - 1), $urandom());
			else
				add_req(OP_WRITE, $urandom_range(1023), $urandom_range(1023), $urandom());
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		operation  = OP_WRITE;
		coord_x    = '0;
		coord_y    = '0;
		pixel_in   = '0;
		cfg_we     = 1'b0;
		cfg_index  = bfs_pkg::CFG_SRC_WIDTH;
		cfg_data   = '0;
		idle_pct   = 12;
		mismatches = 0;
		cycles     = 0;
		taken      = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// sender idles lightly, then heavily, then not at all
		run_phase(8, 6, 20, 15, 32, 24, bfs_pkg::PIX_RGB565, 60, 1'b1);
		run_phase(512, 1, 1024, 3, 1024, 1024, bfs_pkg::PIX_ARGB8888, 60, 1'b1);
		run_phase(1, 64, 5, 600, 2047, 700, bfs_pkg::PIX_RGB565, 60, 1'b0);
		idle_pct = 84;
		run_phase(0, 0, 1, 1, 1, 1, bfs_pkg::PIX_ARGB8888, 40, 1'b1);
		run_phase(1023, 1, 7, 0, 9, 5, bfs_pkg::PIX_RGB565, 40, 1'b0);  // empty dest area
		run_phase(13, 11, 2047, 2047, 40, 30, bfs_pkg::PIX_ARGB8888, 60, 1'b0);
		idle_pct = 0;
		run_phase(16, 9, 31, 17, 50, 20, bfs_pkg::PIX_RGB565, 60, 1'b0);
		run_phase(5, 4, 3, 2, 3, 2, bfs_pkg::PIX_ARGB8888, 60, 1'b0);
		run_phase(12, 10, 7, 9, 7, 9, bfs_pkg::PIX_RGB565, 60, 1'b1);
		drain();

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
